// ===== design/rfut_pkg.sv =====
`default_nettype none
package rfut_pkg;

  localparam logic [14:0] EPOCH_YEAR = 15'd1970;
  localparam logic [23:0] EPOCH_DAYS_ADJ = 24'd477;
  localparam logic [37:0] SEC_PER_DAY = 38'd86400;
  localparam logic [18:0] SEC_PER_HOUR = 19'd3600;
  localparam logic [18:0] SEC_PER_MIN = 19'd60;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } raw_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [6:0] hour;
    logic       pm;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } dec_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic        pm_flag;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] full_year;
  } fld_t;

  typedef struct packed {
    fld_t        fld;
    logic [14:0] fy;
    logic [6:0]  q;
    logic [6:0]  r;
    logic [8:0]  cum_adj;
    logic [16:0] tod;
    logic        err;
  } chk_t;

  typedef struct packed {
    fld_t        fld;
    logic [21:0] days;
    logic [16:0] tod;
    logic        err;
  } days_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    bcd_dec = 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] mo);
    unique case (mo)
      4'd1:    cum_days = 9'd0;
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    unique case (mo)
      4'd2:                       month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
      default:                    month_len = 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/rfut_decode.sv =====
`default_nettype none
module rfut_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          binary_mode,
  input  wire logic          valid_in,
  output logic               ready_out,
  input  wire rfut_pkg::raw_t raw,
  output logic               valid,
  input  wire logic          ready_in,
  output rfut_pkg::dec_t     dec
);

  rfut_pkg::dec_t dec_next;

  assign ready_out = !valid || ready_in;

  always_comb begin
    dec_next.pm = raw.hour[7];
    if (binary_mode) begin
      dec_next.sec     = raw.sec;
      dec_next.min     = raw.min;
      dec_next.hour    = raw.hour[6:0];
      dec_next.day     = raw.day;
      dec_next.month   = raw.month;
      dec_next.year    = raw.year;
      dec_next.century = raw.century;
    end else begin
      dec_next.sec     = rfut_pkg::bcd_dec(raw.sec);
      dec_next.min     = rfut_pkg::bcd_dec(raw.min);
      dec_next.hour    = 7'(raw.hour[3:0]) + 7'(raw.hour[6:4]) * 7'd10;
      dec_next.day     = rfut_pkg::bcd_dec(raw.day);
      dec_next.month   = rfut_pkg::bcd_dec(raw.month);
      dec_next.year    = rfut_pkg::bcd_dec(raw.year);
      dec_next.century = rfut_pkg::bcd_dec(raw.century);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      dec <= dec_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/rfut_check.sv =====
`default_nettype none
module rfut_check (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_in,
  output logic                ready_out,
  input  wire rfut_pkg::dec_t dec,
  output logic                valid,
  input  wire logic           ready_in,
  output rfut_pkg::chk_t      chk
);

  rfut_pkg::chk_t chk_next;
  logic [14:0] fy;
  logic        leap;
  logic [4:0]  ml;
  logic        mo_bad;
  logic [18:0] tod_full;

  assign ready_out = !valid || ready_in;

  always_comb begin
    fy   = 15'(dec.century) * 15'd100 + 15'(dec.year);
    // Only meaningful when year and century are both below 100.
    leap = ((dec.year[1:0] == 2'd0) && (dec.year != 8'd0))
        || ((dec.year == 8'd0) && (dec.century[1:0] == 2'd0));
    ml     = rfut_pkg::month_len(dec.month[3:0], leap);
    mo_bad = (dec.month < 8'd1) || (dec.month > 8'd12);
    tod_full = 19'(dec.hour) * rfut_pkg::SEC_PER_HOUR
             + 19'(dec.min) * rfut_pkg::SEC_PER_MIN + 19'(dec.sec);

    chk_next.fld.seconds      = dec.sec[5:0];
    chk_next.fld.minutes      = dec.min[5:0];
    chk_next.fld.hours        = dec.hour[4:0];
    chk_next.fld.pm_flag      = dec.pm;
    chk_next.fld.day_of_month = dec.day[4:0];
    chk_next.fld.month_number = dec.month[3:0];
    chk_next.fld.full_year    = fy[13:0];
    chk_next.fy               = fy;
    if (dec.year == 8'd0) begin
      chk_next.q = 7'(dec.century - 8'd1);
      chk_next.r = 7'd99;
    end else begin
      chk_next.q = dec.century[6:0];
      chk_next.r = 7'(dec.year - 8'd1);
    end
    chk_next.cum_adj = rfut_pkg::cum_days(dec.month[3:0])
                     + 9'((dec.month > 8'd2) && leap);
    chk_next.tod = tod_full[16:0];
    chk_next.err = (dec.sec > 8'd59) || (dec.min > 8'd59) || (dec.hour > 7'd23)
                || (dec.year > 8'd99) || (dec.century > 8'd99)
                || (fy < rfut_pkg::EPOCH_YEAR) || mo_bad
                || (dec.day < 8'd1) || (dec.day > 8'(ml));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      chk <= chk_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/rfut_days.sv =====
`default_nettype none
module rfut_days (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_in,
  output logic                ready_out,
  input  wire rfut_pkg::chk_t chk,
  output logic                valid,
  input  wire logic           ready_in,
  output rfut_pkg::days_t     dd
);

  rfut_pkg::days_t dd_next;
  logic [23:0] days_full;

  assign ready_out = !valid || ready_in;

  // Gregorian day count relative to the epoch, with leap days from the
  // century split of the previous year.
  always_comb begin
    days_full = 24'(chk.fy - rfut_pkg::EPOCH_YEAR) * 24'd365
              + 24'(chk.q) * 24'd24 + 24'(chk.r[6:2]) + 24'(chk.q[6:2])
              - rfut_pkg::EPOCH_DAYS_ADJ + 24'(chk.cum_adj)
              + 24'(chk.fld.day_of_month) - 24'd1;
    dd_next.fld  = chk.fld;
    dd_next.days = days_full[21:0];
    dd_next.tod  = chk.tod;
    dd_next.err  = chk.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      dd <= dd_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/rfut_scale.sv =====
`default_nettype none
module rfut_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid_in,
  output logic                 ready_out,
  input  wire rfut_pkg::days_t dd,
  output logic                 valid,
  input  wire logic            ready_in,
  output rfut_pkg::fld_t       fld,
  output logic [37:0]          unix_seconds,
  output logic                 range_error
);

  logic [37:0] unix_next;

  assign ready_out = !valid || ready_in;

  always_comb begin
    if (dd.err) begin
      unix_next = 38'd0;
    end else begin
      unix_next = 38'(dd.days) * rfut_pkg::SEC_PER_DAY + 38'(dd.tod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      fld          <= dd.fld;
      unix_seconds <= unix_next;
      range_error  <= dd.err;
    end
  end

endmodule
`default_nettype wire

// ===== design/rtc_fields_to_unix_time.sv =====
// Converts one snapshot of raw real-time-clock bytes into binary calendar
// fields and a Unix seconds count.
// The input channel (in_valid, in_ready) takes one item of seven raw bytes.
// The output channel (out_valid, out_ready) gives one result item per input
// item, in order.
// The configuration port writes binary_mode with cfg_we and cfg_data; write it
// only while no item is in flight. A zero selects BCD decoding.
// The pipeline has four register stages: decode, range check, day count and
// the final multiply by seconds per day. One item can be accepted in every
// cycle while the receiver keeps out_ready high.
// When the receiver stalls, each stage holds its item and in_ready falls once
// the stages ahead are full; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears binary_mode to zero.
// Out-of-range fields set range_error and give a zero seconds count.
`default_nettype none
module rtc_fields_to_unix_time (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sec_raw,
  input  wire logic [7:0]  min_raw,
  input  wire logic [7:0]  hour_raw,
  input  wire logic [7:0]  day_raw,
  input  wire logic [7:0]  month_raw,
  input  wire logic [7:0]  year_raw,
  input  wire logic [7:0]  century_raw,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       seconds,
  output logic [5:0]       minutes,
  output logic [4:0]       hours,
  output logic             pm_flag,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_number,
  output logic [13:0]      full_year,
  output logic [37:0]      unix_seconds,
  output logic             range_error
);

  logic            binary_mode;
  rfut_pkg::raw_t  raw;
  rfut_pkg::dec_t  dec;
  rfut_pkg::chk_t  chk;
  rfut_pkg::days_t dd;
  rfut_pkg::fld_t  fld;
  logic            dec_valid, dec_ready;
  logic            chk_valid, chk_ready;
  logic            dd_valid, dd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode <= 1'b0;
    end else if (cfg_we) begin
      binary_mode <= cfg_data;
    end
  end

  assign raw.sec     = sec_raw;
  assign raw.min     = min_raw;
  assign raw.hour    = hour_raw;
  assign raw.day     = day_raw;
  assign raw.month   = month_raw;
  assign raw.year    = year_raw;
  assign raw.century = century_raw;

  rfut_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .binary_mode (binary_mode),
    .valid_in    (in_valid),
    .ready_out   (in_ready),
    .raw         (raw),
    .valid       (dec_valid),
    .ready_in    (dec_ready),
    .dec         (dec)
  );

  rfut_check u_check (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (dec_valid),
    .ready_out (dec_ready),
    .dec       (dec),
    .valid     (chk_valid),
    .ready_in  (chk_ready),
    .chk       (chk)
  );

  rfut_days u_days (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (chk_valid),
    .ready_out (chk_ready),
    .chk       (chk),
    .valid     (dd_valid),
    .ready_in  (dd_ready),
    .dd        (dd)
  );

  rfut_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (dd_valid),
    .ready_out    (dd_ready),
    .dd           (dd),
    .valid        (out_valid),
    .ready_in     (out_ready),
    .fld          (fld),
    .unix_seconds (unix_seconds),
    .range_error  (range_error)
  );

  assign seconds      = fld.seconds;
  assign minutes      = fld.minutes;
  assign hours        = fld.hours;
  assign pm_flag      = fld.pm_flag;
  assign day_of_month = fld.day_of_month;
  assign month_number = fld.month_number;
  assign full_year    = fld.full_year;

endmodule
`default_nettype wire

// ===== tb/tb_rtc_fields_to_unix_time.sv =====
`default_nettype none
module tb_rtc_fields_to_unix_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic BCD = 1'b0;
  localparam logic BINARY = 1'b1;
  localparam int PROBE_COUNT = 25;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 238;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic        pm_flag;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] full_year;
    logic [37:0] unix_seconds;
    logic        range_error;
  } rtc_time_t;

  typedef struct packed {
    logic           bin;
    rfut_pkg::raw_t raw;
    logic           pinned;
    logic [37:0]    unix;
    logic           err;
  } probe_row_t;

  // Rows with pinned set carry a hand-computed seconds count and error flag;
  // the other fields of every row come from the converter below.
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b0},
    '{BCD, '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99}, 1'b1, 38'd253402300799, 1'b0},
    '{BCD, '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20}, 1'b1, 38'd2147483648, 1'b0},
    '{BCD, '{8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'hA3, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd82800, 1'b0},
    '{BCD, '{8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20}, 1'b0, 38'd0, 1'b0},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h21}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h23, 8'h20}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h59, 8'h59, 8'h23, 8'h30, 8'h04, 8'h24, 8'h20}, 1'b0, 38'd0, 1'b0},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h24, 8'h20}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h0A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19}, 1'b1, 38'd10, 1'b0},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 8'h19}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'hA0}, 1'b1, 38'd0, 1'b1},
    '{BCD, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 38'd0, 1'b1},
    '{BINARY, '{8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd70, 8'd19}, 1'b1, 38'd0, 1'b0},
    '{BINARY, '{8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99, 8'd99}, 1'b1, 38'd253402300799,
      1'b0},
    '{BINARY, '{8'd30, 8'd45, 8'h97, 8'd29, 8'd2, 8'd0, 8'd20}, 1'b0, 38'd0, 1'b0},
    '{BINARY, '{8'd0, 8'd0, 8'h7F, 8'd1, 8'd1, 8'd70, 8'd19}, 1'b1, 38'd0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] sec_raw = '0;
  logic [7:0] min_raw = '0;
  logic [7:0] hour_raw = '0;
  logic [7:0] day_raw = '0;
  logic [7:0] month_raw = '0;
  logic [7:0] year_raw = '0;
  logic [7:0] century_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic pm_flag;
  logic [4:0] day_of_month;
  logic [3:0] month_number;
  logic [13:0] full_year;
  logic [37:0] unix_seconds;
  logic range_error;

  logic pinned_row = 1'b0;
  logic [37:0] pinned_unix = '0;
  logic pinned_err = 1'b0;
  logic mode_shadow = BCD;
  logic mode_now = BCD;
  logic [31:0] stall_pattern = '1;
  logic [4:0] stall_pos = '0;
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  int stuck_cycles = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int range_errors = 0;
  int pm_seen = 0;
  int settings_used = 1;
  rtc_time_t expected_times[$];

  rtc_fields_to_unix_time uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sec_raw(sec_raw),
    .min_raw(min_raw),
    .hour_raw(hour_raw),
    .day_raw(day_raw),
    .month_raw(month_raw),
    .year_raw(year_raw),
    .century_raw(century_raw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .seconds(seconds),
    .minutes(minutes),
    .hours(hours),
    .pm_flag(pm_flag),
    .day_of_month(day_of_month),
    .month_number(month_number),
    .full_year(full_year),
    .unix_seconds(unix_seconds),
    .range_error(range_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned from_bcd(input logic [7:0] b);
    return 10 * int'(b[7:4]) + int'(b[3:0]);
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint unsigned days_before_year(input int unsigned y);
    longint unsigned p;
    p = longint'(y) - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic rtc_time_t convert_snapshot(input logic bin, input rfut_pkg::raw_t r);
    rtc_time_t t;
    int unsigned s, mi, h, d, mo, y, c, fy;
    bit leap, bad;
    longint unsigned days;
    if (bin == BINARY) begin
      s = int'(r.sec);
      mi = int'(r.min);
      h = int'(r.hour[6:0]);
      d = int'(r.day);
      mo = int'(r.month);
      y = int'(r.year);
      c = int'(r.century);
    end else begin
      s = from_bcd(r.sec);
      mi = from_bcd(r.min);
      h = 10 * int'(r.hour[6:4]) + int'(r.hour[3:0]);
      d = from_bcd(r.day);
      mo = from_bcd(r.month);
      y = from_bcd(r.year);
      c = from_bcd(r.century);
    end
    fy = c * 100 + y;
    leap = leap_year(fy);
    bad = s > 59 || mi > 59 || h > 23 || y > 99 || c > 99 || fy < 1970 || mo < 1 || mo > 12;
    if (mo >= 1 && mo <= 12 && (d < 1 || d > days_in_month(mo, leap))) begin
      bad = 1'b1;
    end
    t.unix_seconds = '0;
    if (!bad) begin
      days = days_before_year(fy) - days_before_year(1970) + d - 1;
      for (int unsigned m = 1; m < mo; m++) begin
        days += days_in_month(m, leap);
      end
      t.unix_seconds = 38'(days * 86400 + h * 3600 + mi * 60 + s);
    end
    t.seconds = 6'(s);
    t.minutes = 6'(mi);
    t.hours = 5'(h);
    t.pm_flag = r.hour[7];
    t.day_of_month = 5'(d);
    t.month_number = 4'(mo);
    t.full_year = 14'(fy);
    t.range_error = bad;
    return t;
  endfunction

  function automatic logic [7:0] encode_field(input logic bin, input int unsigned v);
    if (bin == BINARY) begin
      return 8'(v);
    end
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rfut_pkg::raw_t random_snapshot(input logic bin);
    rfut_pkg::raw_t r;
    int unsigned kind, yr, mo, mlen, dy, f;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      r = 56'({$urandom(), $urandom()});
      return r;
    end
    case ($urandom_range(0, 9))
      0: yr = $urandom_range(1970, 1975);
      1: yr = $urandom_range(9990, 9999);
      2: yr = 100 * $urandom_range(20, 99);
      3: yr = $urandom_range(1999, 2001);
      default: yr = $urandom_range(1970, 9999);
    endcase
    mo = $urandom_range(1, 12);
    mlen = days_in_month(mo, leap_year(yr));
    dy = ($urandom_range(0, 3) == 0) ? mlen : $urandom_range(1, mlen);
    if (kind >= 80) begin
      if ($urandom_range(0, 1) == 1) begin
        dy = mlen + 1;
      end else begin
        yr = $urandom_range(0, 1969);
      end
    end
    r.sec = encode_field(bin, $urandom_range(0, 59));
    r.min = encode_field(bin, $urandom_range(0, 59));
    r.hour = {1'($urandom_range(0, 1)), 7'(encode_field(bin, $urandom_range(0, 23)))};
    r.day = encode_field(bin, dy);
    r.month = encode_field(bin, mo);
    r.year = encode_field(bin, yr % 100);
    r.century = encode_field(bin, yr / 100);
    if (kind >= 70 && kind < 80) begin
      f = $urandom_range(0, 6);
      r[8 * f +: 8] = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_checked, name, got, want));
    end
  endtask

  task automatic send_snapshot(input rfut_pkg::raw_t r, input logic pinned,
                               input logic [37:0] unix, input logic err);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sec_raw <= r.sec;
    min_raw <= r.min;
    hour_raw <= r.hour;
    day_raw <= r.day;
    month_raw <= r.month;
    year_raw <= r.year;
    century_raw <= r.century;
    pinned_row <= pinned;
    pinned_unix <= unix;
    pinned_err <= err;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    mode_shadow <= m;
    mode_now = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    out_ready <= stall_pattern[stall_pos];
    stall_pos <= stall_pos + 5'd1;
  end

  always @(posedge clk) begin
    rfut_pkg::raw_t snap;
    rtc_time_t want;
    if (!rst && in_valid && in_ready) begin
      snap = '{sec_raw, min_raw, hour_raw, day_raw, month_raw, year_raw, century_raw};
      want = convert_snapshot(mode_shadow, snap);
      if (pinned_row) begin
        want.unix_seconds = pinned_unix;
        want.range_error = pinned_err;
      end
      expected_times.push_back(want);
    end
  end

  always @(posedge clk) begin
    rtc_time_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{seconds, minutes, hours, pm_flag, day_of_month, month_number, full_year,
              unix_seconds, range_error};
      if (expected_times.size() == 0) begin
        report_mismatch($sformatf("result with no item pending, unix_seconds %0d",
                                  unix_seconds));
      end else begin
        want = expected_times.pop_front();
        results_checked++;
        if (want.range_error) range_errors++;
        if (want.pm_flag) pm_seen++;
        check_field("seconds", 64'(got.seconds), 64'(want.seconds));
        check_field("minutes", 64'(got.minutes), 64'(want.minutes));
        check_field("hours", 64'(got.hours), 64'(want.hours));
        check_field("pm_flag", 64'(got.pm_flag), 64'(want.pm_flag));
        check_field("day_of_month", 64'(got.day_of_month), 64'(want.day_of_month));
        check_field("month_number", 64'(got.month_number), 64'(want.month_number));
        check_field("full_year", 64'(got.full_year), 64'(want.full_year));
        check_field("unix_seconds", 64'(got.unix_seconds), 64'(want.unix_seconds));
        check_field("range_error", 64'(got.range_error), 64'(want.range_error));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, expected_times.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    gap_max = 2;
    stall_pattern <= $urandom() | 32'h1;
    for (int i = 0; i < PROBE_COUNT; i++) begin
      if (PROBE_ROWS[i].bin != mode_now) begin
        in_valid <= 1'b0;
        set_mode(PROBE_ROWS[i].bin);
      end
      send_snapshot(PROBE_ROWS[i].raw, PROBE_ROWS[i].pinned, PROBE_ROWS[i].unix,
                    PROBE_ROWS[i].err);
    end
    in_valid <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(ph % 2 == 0 ? BCD : BINARY);
      gap_max = (ph == 0) ? 0 : $urandom_range(1, 8);
      stall_pattern <= (ph == 0) ? '1 : ($urandom() | 32'h1);
      burst_left = 0;
      repeat (PHASE_ITEMS) send_snapshot(random_snapshot(mode_now), 1'b0, '0, 1'b0);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("checked %0d snapshot results across %0d converter settings (BCD and binary)",
             results_checked, settings_used);
    $display("%0d of them out of range, %0d with the PM bit set", range_errors, pm_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
